/* hdl/pbp_pkg.sv */
package pbp_pkg;

    // table geometry (NUM_ROWS must be a power of two)
    localparam int NUM_ROWS     = 512;
    localparam int HISTORY_BITS = 63;
    localparam int ROW_LEN      = HISTORY_BITS + 1;
    localparam int ROW_W        = $clog2(NUM_ROWS);
    localparam int WEIGHT_W     = 8;
    localparam int ROW_BITS     = ROW_LEN * WEIGHT_W;

    // adder tree: groups of eight weights, then a sum of the groups
    localparam int GRP_SIZE = 8;
    localparam int NUM_GRP  = (ROW_LEN + GRP_SIZE - 1) / GRP_SIZE;
    localparam int TERM_W   = WEIGHT_W + 1;
    localparam int GRP_W    = TERM_W + $clog2(GRP_SIZE);

    // field widths
    localparam int PC_W    = 32;
    localparam int SUM_W   = 14;
    localparam int THR_W   = 14;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(135);

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 8'sd127;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = -8'sd128;

    // word kind on the input tuser
    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch accepted input word
        logic rd;       // read table row
        logic psum;     // register group partial sums
        logic fin;      // register full sum
        logic wb;       // train decision and row write-back
        logic put;      // load output register
        logic clr;      // clear one table row
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_update;
        logic out_free;
    } t_sts;

endpackage

/* hdl/pbp_ctrl.sv */
module pbp_ctrl
    import pbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_RD   = 7'b0000100,
        S_PSUM = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_WB   = 7'b0100000,
        S_PUT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = i_sts.is_update ? S_WB : S_PSUM;
            end
            S_PSUM: begin
                o_cmd.psum = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_PUT;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_PUT;
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

endmodule

/* hdl/pbp_datapath.sv */
module pbp_datapath
    import pbp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_kind,
    input  logic [PC_W-1:0]         i_pc,
    input  logic                    i_taken,
    input  logic                    i_predicted,
    input  logic                    i_cfg_we,
    input  logic [THR_W-1:0]        i_cfg_wdata,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_out_pred,
    output logic signed [SUM_W-1:0] o_out_sum,
    output logic                    o_out_trained
);

    // table: one row of ROW_LEN weights per entry, weight k at bits [8k+7:8k]
    logic [ROW_BITS-1:0] r_mem [NUM_ROWS];
    logic [ROW_BITS-1:0] r_rdata;

    logic [ROW_W-1:0] r_clr_cnt;

    // captured word
    logic             r_kind;
    logic [ROW_W-1:0] r_row;
    logic             r_taken;
    logic             r_predicted;

    logic [HISTORY_BITS-1:0] r_hist;
    logic signed [SUM_W-1:0] r_last_sum;
    logic [THR_W-1:0]        r_thr;

    logic signed [GRP_W-1:0] r_part [NUM_GRP];
    logic signed [GRP_W-1:0] n_part [NUM_GRP];
    logic signed [SUM_W-1:0] n_sum;

    logic [ROW_BITS-1:0] n_row;
    logic [SUM_W-1:0]    w_mag;
    logic                w_train;
    logic                r_train;

    logic                w_we;
    logic [ROW_W-1:0]    w_waddr;
    logic [ROW_BITS-1:0] w_wdata;

    logic                    r_out_valid;
    logic                    r_out_pred;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_trained;

    // ---------------- table memory ----------------
    assign w_we    = i_cmd.clr | (i_cmd.wb & w_train);
    assign w_waddr = i_cmd.clr ? r_clr_cnt : r_row;
    assign w_wdata = i_cmd.clr ? '0 : n_row;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // ---------------- input capture ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind      <= i_kind;
            r_row       <= i_pc[ROW_W-1:0];
            r_taken     <= i_taken;
            r_predicted <= i_predicted;
        end
    end

    // ---------------- dot product ----------------
    always_comb begin
        logic signed [TERM_W-1:0] term;
        logic signed [TERM_W-1:0] wext;
        int k;
        term = '0;
        wext = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            n_part[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                k = g * GRP_SIZE + j;
                if (k < ROW_LEN) begin
                    wext = TERM_W'($signed(r_rdata[k*WEIGHT_W +: WEIGHT_W]));
                    if (k == 0) begin
                        term = wext;
                    end else begin
                        term = r_hist[k-1] ? wext : -wext;
                    end
                    n_part[g] = n_part[g] + GRP_W'(term);
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            n_sum = n_sum + SUM_W'(r_part[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.psum) begin
            r_part <= n_part;
        end
    end

    // ---------------- training ----------------
    assign w_mag   = r_last_sum[SUM_W-1] ? SUM_W'(-r_last_sum) : SUM_W'(r_last_sum);
    assign w_train = (r_taken != r_predicted) || (w_mag <= r_thr);

    always_comb begin
        logic signed [WEIGHT_W-1:0] w;
        logic up;
        w  = '0;
        up = 1'b0;
        for (int k = 0; k < ROW_LEN; k++) begin
            w = r_rdata[k*WEIGHT_W +: WEIGHT_W];
            if (k == 0) begin
                up = r_taken;
            end else begin
                up = (r_hist[k-1] == r_taken);
            end
            if (up) begin
                if (w != WEIGHT_MAX) begin
                    w = w + 1'b1;
                end
            end else begin
                if (w != WEIGHT_MIN) begin
                    w = w - 1'b1;
                end
            end
            n_row[k*WEIGHT_W +: WEIGHT_W] = w;
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_last_sum <= '0;
            r_thr      <= THR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.fin) begin
                r_last_sum <= n_sum;
            end
            if (i_cmd.wb) begin
                r_hist <= {r_hist[HISTORY_BITS-2:0], r_taken};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_train <= w_train;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out_sum <= r_last_sum;
            if (r_kind == KIND_UPDATE) begin
                r_out_pred    <= 1'b0;
                r_out_trained <= r_train;
            end else begin
                r_out_pred    <= ~r_last_sum[SUM_W-1];
                r_out_trained <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_pred    = r_out_pred;
    assign o_out_sum     = r_out_sum;
    assign o_out_trained = r_out_trained;

    assign o_sts.clr_last  = (r_clr_cnt == ROW_W'(NUM_ROWS - 1));
    assign o_sts.is_update = (r_kind == KIND_UPDATE);
    assign o_sts.out_free  = ~r_out_valid | i_out_ready;

endmodule

/* hdl/perceptron_branch_predictor_unit.sv */
// Channel  | Dir | Handshake                    | Payload
// ---------+-----+------------------------------+------------------------------------------
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: kind; tdata: pc, taken, predicted
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: predict_taken, perceptron_sum, trained
// cfg      | in  | i_cfg_we (no wait)           | i_cfg_wdata: train_threshold
//
// A predict word goes through accept, row read, group sums, total and output load;
// an update word through accept, row read, train and write-back and output load. One word
// is in flight at a time; the row read and the history it needs set the pace.
// After reset a clearing pass zeroes the table, one row per cycle, with s_axis_tready
// low until the last of the NUM_ROWS (512) rows is cleared. Config writes are taken at any time.
// The output register holds a result until taken; the next word is accepted meanwhile and
// stalls only at its output load.
module perceptron_branch_predictor_unit
    import pbp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] pc, [32] taken, [33] predicted
    input  logic [0:0]             s_axis_tuser,   // [0] kind: 0 predict, 1 update
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] predict_taken, [14:1] sum, [15] trained
    // threshold register
    input  logic                   i_cfg_we,
    input  logic [THR_W-1:0]       i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    logic                    w_out_pred;
    logic signed [SUM_W-1:0] w_out_sum;
    logic                    w_out_trained;

    // sequencing: clear sweep, then per-word read / sum / train / output
    pbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // weight table, adder tree, training lanes, history and output register
    pbp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (s_axis_tuser[0]),
        .i_pc          (s_axis_tdata[PC_W-1:0]),
        .i_taken       (s_axis_tdata[PC_W]),
        .i_predicted   (s_axis_tdata[PC_W+1]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_pred    (w_out_pred),
        .o_out_sum     (w_out_sum),
        .o_out_trained (w_out_trained)
    );

    assign m_axis_tdata = {w_out_trained, w_out_sum, w_out_pred};

endmodule
